// ----- rtl/core/mwpid_pkg.sv -----
// ----------------------------------------------------------------------------
// mwpid_pkg
// Shared types, register indexes and arithmetic helpers of the multi-wheel
// PID speed controller.
// ----------------------------------------------------------------------------
package mwpid_pkg;

	localparam int RPM_W   = 16;   // target / measured speed width
	localparam int DRIVE_W = 31;   // drive magnitude width
	localparam int GAIN_W  = 32;   // Q16.16 gain width
	localparam int LIM_W   = 31;   // integrator limit width
	localparam int PULSE_W = 20;   // open-loop full-scale width
	localparam int CFG_W   = 32;   // config write data width

	localparam logic [DRIVE_W-1:0] DRIVE_MAX = '1;

	// Open-loop divide by 795: reciprocal floor(2^35/795), then one correction
	localparam logic [25:0] OL_RECIP = 26'd43219796;
	localparam logic [9:0]  OL_DIV   = 10'd795;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PID_ENABLE     = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_MAX_PULSE      = 3'd5
	} reg_idx_t;

	// Live configuration seen by every lane and the open-loop path
	typedef struct packed {
		logic                      pid_enable;
		logic signed [GAIN_W-1:0]  gain_p;
		logic signed [GAIN_W-1:0]  gain_i;
		logic signed [GAIN_W-1:0]  gain_d;
		logic        [LIM_W-1:0]   integral_limit;
		logic        [PULSE_W-1:0] max_pulse;
	} cfg_t;

	// Pipeline control broadcast to the lanes
	typedef struct packed {
		logic adv;      // all stages shift this cycle
		logic take_s0;  // closed-loop item entering stage 1
		logic take_s3;  // closed-loop item moving from stage 3 to stage 4
	} pipe_ctl_t;

	// Q16.16 product scaled back to integer, truncated toward zero
	function automatic logic signed [33:0] q16_trunc(input logic signed [49:0] a);
		logic signed [49:0] sh;
		sh = a >>> 16;
		if (a[49] && (a[15:0] != 16'd0)) begin
			sh = sh + 50'sd1;
		end
		return sh[33:0];
	endfunction

endpackage

// ----- rtl/core/mwpid_lane.sv -----
// ----------------------------------------------------------------------------
// mwpid_lane
// One wheel's PID datapath: error, gain products, truncation, clamped
// integrator, term sum and saturated magnitude over six stages.
// ----------------------------------------------------------------------------
module mwpid_lane
	import mwpid_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  pipe_ctl_t                 ctl,
	input  cfg_t                      cfg,
	input  logic signed [RPM_W-1:0]   target,
	input  logic signed [RPM_W-1:0]   measured,
	output logic        [DRIVE_W-1:0] drive
);

	logic signed [16:0] err, last_err_q, err_s1;
	logic signed [17:0] derr, derr_s1;
	logic signed [49:0] pp_s2, ip_s2, dp_s2;
	logic signed [33:0] p_s3, inc_s3, d_s3;
	logic signed [31:0] int_q, acc_s4;
	logic signed [34:0] pd_s4;
	logic signed [34:0] acc_sum, lim, acc_clamp;
	logic signed [35:0] sum_s5;
	logic        [35:0] mag;
	logic [DRIVE_W-1:0] drive_s6;

	// error and error difference against the previous tick
	assign err  = 17'(target) - 17'(measured);
	assign derr = 18'(err) - 18'(last_err_q);

	// integrator add and symmetric clamp
	always_comb begin
		acc_sum = 35'(int_q) + 35'(inc_s3);
		lim     = $signed({4'd0, cfg.integral_limit});
		if (acc_sum >= lim) begin
			acc_clamp = lim;
		end else if (acc_sum <= -lim) begin
			acc_clamp = -lim;
		end else begin
			acc_clamp = acc_sum;
		end
	end

	// magnitude of the term sum
	assign mag = sum_s5[35] ? 36'(-sum_s5) : 36'(sum_s5);

	// per-wheel state: previous error and integrator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			int_q      <= '0;
		end else begin
			if (ctl.take_s0) begin
				last_err_q <= err;
			end
			if (ctl.take_s3) begin
				int_q <= acc_clamp[31:0];
			end
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			err_s1  <= err;
			derr_s1 <= derr;
			pp_s2   <= 50'(err_s1) * 50'(cfg.gain_p);
			ip_s2   <= 50'(err_s1) * 50'(cfg.gain_i);
			dp_s2   <= 50'(derr_s1) * 50'(cfg.gain_d);
			p_s3    <= q16_trunc(pp_s2);
			inc_s3  <= q16_trunc(ip_s2);
			d_s3    <= q16_trunc(dp_s2);
			acc_s4  <= acc_clamp[31:0];
			pd_s4   <= 35'(p_s3) + 35'(d_s3);
			sum_s5  <= 36'(pd_s4) + 36'(acc_s4);
			if (mag > 36'(DRIVE_MAX)) begin
				drive_s6 <= DRIVE_MAX;
			end else begin
				drive_s6 <= mag[DRIVE_W-1:0];
			end
		end
	end

	assign drive = drive_s6;

endmodule

// ----- rtl/core/mwpid_open.sv -----
// ----------------------------------------------------------------------------
// mwpid_open
// Open-loop drive: max_pulse * |target| / 795 by reciprocal multiply with a
// single correction step, six stages, plus the direction bit.
// ----------------------------------------------------------------------------
module mwpid_open
	import mwpid_pkg::*;
(
	input  logic                      clk,
	input  logic                      adv,
	input  cfg_t                      cfg,
	input  logic signed [RPM_W-1:0]   target,
	output logic        [DRIVE_W-1:0] drive,
	output logic                      forward
);

	logic [RPM_W-1:0] tmag, tmag_s1;
	logic [34:0] x_s2, x_s3, x_s4, x_s5;
	logic [43:0] ph_s3;
	logic [42:0] pl_s3;
	logic [60:0] prod_sum;
	logic [25:0] q0_s4, q0_s5, q_s6;
	logic [35:0] qm_s5, rem;
	logic fwd_s1, fwd_s2, fwd_s3, fwd_s4, fwd_s5, fwd_s6;

	assign tmag     = target[RPM_W-1] ? (~target + 16'd1) : target;
	assign prod_sum = (61'(ph_s3) << 17) + 61'(pl_s3);
	assign rem      = 36'(x_s5) - qm_s5;

	// reciprocal pipeline; quotient estimate is exact or one low
	always_ff @(posedge clk) begin
		if (adv) begin
			tmag_s1 <= tmag;
			fwd_s1  <= ~target[RPM_W-1];
			x_s2    <= 35'(cfg.max_pulse) * 35'(tmag_s1);
			fwd_s2  <= fwd_s1;
			ph_s3   <= 44'(x_s2[34:17]) * 44'(OL_RECIP);
			pl_s3   <= 43'(x_s2[16:0]) * 43'(OL_RECIP);
			x_s3    <= x_s2;
			fwd_s3  <= fwd_s2;
			q0_s4   <= prod_sum[60:35];
			x_s4    <= x_s3;
			fwd_s4  <= fwd_s3;
			qm_s5   <= 36'(q0_s4) * 36'(OL_DIV);
			q0_s5   <= q0_s4;
			x_s5    <= x_s4;
			fwd_s5  <= fwd_s4;
			q_s6    <= (rem >= 36'(OL_DIV)) ? (q0_s5 + 26'd1) : q0_s5;
			fwd_s6  <= fwd_s5;
		end
	end

	assign drive   = DRIVE_W'(q_s6);
	assign forward = fwd_s6;

endmodule

// ----- rtl/core/mwpid_obuf.sv -----
// ----------------------------------------------------------------------------
// mwpid_obuf
// Output register with one skid entry; upstream ready is registered.
// ----------------------------------------------------------------------------
module mwpid_obuf #(
	parameter int WIDTH = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             out_vld_q, skid_vld_q;
	logic [WIDTH-1:0] out_q, skid_q;
	logic             in_fire;

	assign in_ready = ~skid_vld_q;
	assign in_fire  = in_valid & in_ready;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (out_vld_q && !out_ready) begin
				skid_vld_q <= 1'b1;
			end
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (in_fire) begin
			if (out_vld_q && !out_ready) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/core/multi_wheel_pid_speed_control_top.sv -----
// Path: an input transfer passes the six pipeline stages, then the output
//   register, before its result appears on the output.
// Throughput: one tick per cycle; the six-stage lane and open-loop pipelines
//   advance together and stall only when both output entries are full.
// Reset: arst_n clears config registers, integrators, last errors and valids.
// ----------------------------------------------------------------------------
// multi_wheel_pid_speed_control_top
// Per-wheel PID lanes with clamped integrators, an open-loop scaling path,
// a mode merge and a streaming output buffer.
// ----------------------------------------------------------------------------
module multi_wheel_pid_speed_control_top
	import mwpid_pkg::*;
#(
	parameter int LANES = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// config write port
	input  logic                                   cfg_we,
	input  logic [2:0]                             cfg_addr,
	input  logic [CFG_W-1:0]                       cfg_wdata,
	// input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// target_rpm, measured_rpm_0 .. measured_rpm_(LANES-1)
	input  logic [RPM_W*(LANES+1)-1:0]             s_tdata,
	// output stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// drive_0 .. drive_(LANES-1), forward, zero fill
	output logic [((DRIVE_W*LANES+8)/8)*8-1:0]     m_tdata
);

	localparam int OUT_W = ((DRIVE_W*LANES+8)/8)*8;

	cfg_t      cfg_q;
	pipe_ctl_t ctl;
	logic      adv;
	logic      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [RPM_W-1:0] target;
	logic [DRIVE_W-1:0] lane_drive [LANES];
	logic [DRIVE_W-1:0] ol_drive;
	logic               ol_fwd;
	logic [OUT_W-1:0]   res_data;

	assign target   = s_tdata[RPM_W-1:0];
	assign s_tready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_PID_ENABLE:     cfg_q.pid_enable     <= cfg_wdata[0];
				REG_GAIN_P:         cfg_q.gain_p         <= cfg_wdata;
				REG_GAIN_I:         cfg_q.gain_i         <= cfg_wdata;
				REG_GAIN_D:         cfg_q.gain_d         <= cfg_wdata;
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_wdata[LIM_W-1:0];
				REG_MAX_PULSE:      cfg_q.max_pulse      <= cfg_wdata[PULSE_W-1:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// state updates happen only for closed-loop items
	assign ctl.adv     = adv;
	assign ctl.take_s0 = adv & s_tvalid & cfg_q.pid_enable;
	assign ctl.take_s3 = adv & v_s3 & cfg_q.pid_enable;

	// wheel lanes
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mwpid_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cfg      (cfg_q),
			.target   (target),
			.measured (s_tdata[RPM_W*(i+1) +: RPM_W]),
			.drive    (lane_drive[i])
		);
	end

	// open-loop path
	mwpid_open u_open (
		.clk     (clk),
		.adv     (adv),
		.cfg     (cfg_q),
		.target  (target),
		.drive   (ol_drive),
		.forward (ol_fwd)
	);

	// merge: pick per mode and pack the result
	always_comb begin
		res_data = '0;
		for (int i = 0; i < LANES; i++) begin
			res_data[DRIVE_W*i +: DRIVE_W] = cfg_q.pid_enable ? lane_drive[i] : ol_drive;
		end
		res_data[DRIVE_W*LANES] = ol_fwd;
	end

	mwpid_obuf #(
		.WIDTH (OUT_W)
	) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_ready  (adv),
		.in_data   (res_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-wheel PID speed controller. A scoreboard
// class predicts the drive of every wheel from each accepted control tick,
// keeps its own copy of the integrators, last errors and registers, and
// checks every output transfer in order. Directed ticks cover the field
// extremes, saturation, integrator clamping and both modes. Random phases
// with fresh register settings follow, under random source and sink stalls.
// ----------------------------------------------------------------------------
module testbench
	import mwpid_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES       = 4;
	localparam int IN_W        = RPM_W * (LANES + 1);
	localparam int OUT_W       = ((DRIVE_W * LANES + 8) / 8) * 8;
	localparam int LATENCY     = 7;
	localparam int HOLD_CYCLES = 48;    // long sink hold-off, fills the pipe
	localparam int STALL_LIMIT = 1000;  // cycles without any transfer
	localparam int RAND_PHASES = 8;
	localparam int PHASE_TICKS = 106;

	localparam longint Q16_ONE       = 64'sd65536;
	localparam longint OPEN_LOOP_DIV = 64'sd795;
	localparam longint DRIVE_LIMIT   = 64'sd2147483647;

	// one control tick, target in the low bits
	typedef struct packed {
		logic [LANES-1:0][RPM_W-1:0] meas;
		logic [RPM_W-1:0]            target;
	} tick_t;

	// one result, drive_0 in the low bits
	typedef struct packed {
		logic                          forward;
		logic [LANES-1:0][DRIVE_W-1:0] drive;
	} drives_t;

	// ------------------------------------------------------------------
	// Drive predictor and in-order checker
	// ------------------------------------------------------------------
	class drive_scoreboard;
		bit      closed_loop;
		longint  kp, ki, kd, i_limit, pulse_full;
		longint  integ[LANES];
		longint  prev_err[LANES];
		drives_t expected_drives[$];
		int      errors, n_ticks, n_closed, n_sat, n_clamp;

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_PID_ENABLE:     closed_loop = v[0];
				REG_GAIN_P:         kp = longint'($signed(v));
				REG_GAIN_I:         ki = longint'($signed(v));
				REG_GAIN_D:         kd = longint'($signed(v));
				REG_INTEGRAL_LIMIT: i_limit = longint'(v[LIM_W-1:0]);
				REG_MAX_PULSE:      pulse_full = longint'(v[PULSE_W-1:0]);
				default: ;
			endcase
		endfunction

		function drives_t compute_drives(tick_t t);
			drives_t r;
			longint  tgt, err, p, acc, d, sum, mag;
			tgt = longint'($signed(t.target));
			for (int i = 0; i < LANES; i++) begin
				if (closed_loop) begin
					err = tgt - longint'($signed(t.meas[i]));
					p   = (err * kp) / Q16_ONE;
					acc = integ[i] + (err * ki) / Q16_ONE;
					d   = ((err - prev_err[i]) * kd) / Q16_ONE;
					// symmetric integrator clamp; a zero limit pins it at zero
					if (acc >= i_limit) begin
						if (acc > i_limit) n_clamp++;
						acc = i_limit;
					end else if (acc <= -i_limit) begin
						if (acc < -i_limit) n_clamp++;
						acc = -i_limit;
					end
					integ[i]    = acc;
					prev_err[i] = err;
					sum = p + acc + d;
				end else begin
					// open loop: integrators and last errors held
					sum = (pulse_full * tgt) / OPEN_LOOP_DIV;
				end
				mag = (sum < 0) ? -sum : sum;
				if (mag > DRIVE_LIMIT) begin
					mag = DRIVE_LIMIT;
					n_sat++;
				end
				r.drive[i] = mag[DRIVE_W-1:0];
			end
			r.forward = (tgt >= 0);
			return r;
		endfunction

		function void note_tick(tick_t t);
			n_ticks++;
			if (closed_loop) n_closed++;
			expected_drives.push_back(compute_drives(t));
		endfunction

		function void check_drive(logic [OUT_W-1:0] data);
			drives_t got, want;
			got = drives_t'(data[$bits(drives_t)-1:0]);
			if (expected_drives.size() == 0) begin
				errors++;
				$display("%0t: output transfer with no tick outstanding, data %h", $time, data);
				return;
			end
			want = expected_drives.pop_front();
			for (int i = 0; i < LANES; i++) begin
				if (got.drive[i] !== want.drive[i]) begin
					errors++;
					$display("%0t: drive_%0d expected %0d, actual %0d",
						$time, i, want.drive[i], got.drive[i]);
				end
			end
			if (got.forward !== want.forward) begin
				errors++;
				$display("%0t: forward expected %0b, actual %0b",
					$time, want.forward, got.forward);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Signals and DUT
	// ------------------------------------------------------------------
	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [2:0]       cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	drive_scoreboard sb = new();

	bit calm;            // no idling on either side
	int hold_req;        // long sink hold-offs requested
	int hold_done;       // long sink hold-offs carried out
	int n_settings;
	int idle_cycles;

	multi_wheel_pid_speed_control_top #(
		.LANES(LANES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// transfer monitors
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_tick(tick_t'(s_tdata));
		if (arst_n && m_tvalid && m_tready) sb.check_drive(m_tdata);
	end

	// watchdog on cycles without any transfer or config write
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("** multi_wheel_pid_speed_control_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// sink: random stall bursts, plus long hold-offs on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_done < hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done++;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_tick(input tick_t t);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(t);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_rpms(input logic [15:0] tgt, m0, m1, m2, m3);
		tick_t t;
		t.target  = tgt;
		t.meas[0] = m0;
		t.meas[1] = m1;
		t.meas[2] = m2;
		t.meas[3] = m3;
		send_tick(t);
	endtask

	task automatic source_gap(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// drain the pipe before touching the registers
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_drives.size() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_rpm();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4, 5: return 16'($urandom_range(0, 2000) - 1000);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		t.target = pick_rpm();
		for (int i = 0; i < LANES; i++) begin
			// about half the wheels close to the target, the rest picked freely
			if ($urandom_range(0, 1) == 1)
				t.meas[i] = 16'(32'(t.target) + $urandom_range(0, 600) - 32'd300);
			else
				t.meas[i] = pick_rpm();
		end
		return t;
	endfunction

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536);
			3: return $urandom();
			4: return 32'($urandom_range(0, 256 * 65536)) - 32'(128 * 65536);
			default: return 32'h0;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'($urandom_range(1, 1000));
			2: return 32'($urandom_range(0, 1 << 24));
			3: return $urandom() & 32'h7FFF_FFFF;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_pulse();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'd1000000;
			2: return 32'h000F_FFFF;
			default: return 32'($urandom_range(0, 1000000));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		bit pid_on;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		calm      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: open loop with zero full scale
		n_settings = 1;
		send_rpms(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
		send_rpms(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001);

		// open loop at the largest full scale, both directions
		wait_idle();
		n_settings++;
		set_reg(REG_PID_ENABLE, 32'd0);
		set_reg(REG_MAX_PULSE, 32'h000F_FFFF);
		send_rpms(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_rpms(16'h8000, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
		send_rpms(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_rpms(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_rpms(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

		// extreme gains: drive saturation, largest error swings
		wait_idle();
		n_settings++;
		set_reg(REG_PID_ENABLE, 32'd1);
		set_reg(REG_GAIN_P, 32'h7FFF_FFFF);
		set_reg(REG_GAIN_I, 32'h8000_0000);
		set_reg(REG_GAIN_D, 32'h7FFF_FFFF);
		set_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
		send_rpms(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
		send_rpms(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001);
		send_rpms(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_rpms(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);

		// fractional I gain, negative errors truncate toward zero, zero limit
		wait_idle();
		n_settings++;
		set_reg(REG_GAIN_P, 32'h0001_0000);
		set_reg(REG_GAIN_I, 32'h0000_8000);
		set_reg(REG_GAIN_D, 32'hFFFF_0000);
		set_reg(REG_INTEGRAL_LIMIT, 32'd0);
		send_rpms(16'hFFFD, 16'h0000, 16'h0002, 16'hFFF9, 16'h0005);
		send_rpms(16'h0005, 16'h0000, 16'h0008, 16'hFFFF, 16'h0006);
		send_rpms(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005);
		send_rpms(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE, 16'h0002);

		// small limit: integrator runs into both clamp sides
		wait_idle();
		n_settings++;
		set_reg(REG_GAIN_P, 32'd0);
		set_reg(REG_GAIN_I, 32'h0001_0000);
		set_reg(REG_GAIN_D, 32'd0);
		set_reg(REG_INTEGRAL_LIMIT, 32'd100);
		repeat (2) send_rpms(16'd1000, 16'd0, 16'd0, 16'd2000, 16'hFC18);
		send_rpms(16'd60, 16'd0, 16'd0, 16'd0, 16'd0);
		repeat (2) send_rpms(16'hFC18, 16'd0, 16'd0, 16'd0, 16'd0);

		// open loop holds the PID state, closed loop then resumes from it
		wait_idle();
		n_settings++;
		set_reg(REG_PID_ENABLE, 32'd0);
		set_reg(REG_MAX_PULSE, 32'd1000000);
		send_rpms(16'd795, 16'd1, 16'd2, 16'd3, 16'd4);
		send_rpms(16'hFCE5, 16'd1, 16'd2, 16'd3, 16'd4);
		wait_idle();
		n_settings++;
		set_reg(REG_PID_ENABLE, 32'd1);
		send_rpms(16'd10, 16'd0, 16'd0, 16'd0, 16'd0);
		send_rpms(16'd10, 16'd0, 16'd0, 16'd0, 16'd0);

		// random phases with fresh settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			n_settings++;
			if (ph == 2)      pid_on = 1'b0;
			else if (ph == 3) pid_on = 1'b1;
			else              pid_on = ($urandom_range(0, 3) != 0);
			set_reg(REG_PID_ENABLE, {31'd0, pid_on});
			if (ph == 0 || $urandom_range(0, 3) != 0) set_reg(REG_GAIN_P, pick_gain());
			if (ph == 0 || $urandom_range(0, 3) != 0) set_reg(REG_GAIN_I, pick_gain());
			if (ph == 0 || $urandom_range(0, 3) != 0) set_reg(REG_GAIN_D, pick_gain());
			if (ph == 0 || $urandom_range(0, 3) != 0) set_reg(REG_INTEGRAL_LIMIT, pick_limit());
			if (ph == 0 || $urandom_range(0, 3) != 0) set_reg(REG_MAX_PULSE, pick_pulse());
			calm = (ph == RAND_PHASES - 1);
			if (ph == 1) hold_req++;
			for (int k = 0; k < PHASE_TICKS; k++) begin
				if (!calm && $urandom_range(0, 4) == 0) source_gap($urandom_range(1, 8));
				send_tick(random_tick());
			end
		end

		wait_idle();
		$display("Ran %0d control ticks (%0d closed-loop, %0d open-loop) over %0d settings.",
			sb.n_ticks, sb.n_closed, sb.n_ticks - sb.n_closed, n_settings);
		$display("Saw %0d saturated drives, %0d integrator clamps, %0d long sink hold-offs.",
			sb.n_sat, sb.n_clamp, hold_done);
		if (sb.errors == 0 && sb.expected_drives.size() == 0) begin
			$display("** multi_wheel_pid_speed_control_top: PASSED **");
		end else begin
			$display("** multi_wheel_pid_speed_control_top: FAILED **");
		end
		$finish;
	end

endmodule
